// ----- hdl/idm_pkg.sv -----
`default_nettype none

package idm_pkg;

  localparam int DATA_W = 32;

  // opcode codes
  localparam logic [1:0] OP_UDIV = 2'd0;
  localparam logic [1:0] OP_UREM = 2'd1;
  localparam logic [1:0] OP_SDIV = 2'd2;
  localparam logic [1:0] OP_SREM = 2'd3;

  // how the final word is formed from the quotient and remainder
  typedef struct packed {
    logic sel_rem;   // deliver remainder instead of quotient
    logic negate;    // two's complement the selected word
    logic zero_div;  // divisor was zero: deliver 0
  } ctrl_t;

  // payload handed from cell to cell
  typedef struct packed {
    ctrl_t             ctrl;
    logic [DATA_W-1:0] rem;  // partial remainder
    logic [DATA_W-1:0] nq;   // dividend bits shift out the top, quotient bits in the bottom
    logic [DATA_W-1:0] den;  // divisor magnitude
  } stage_t;

endpackage

`default_nettype wire

// ----- hdl/idm_prep.sv -----
`default_nettype none

module idm_prep (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       vin,
  input  wire logic [1:0]                 opcode,
  input  wire logic [idm_pkg::DATA_W-1:0] dividend,
  input  wire logic [idm_pkg::DATA_W-1:0] divisor,
  output logic                            vout,
  output idm_pkg::stage_t                 dout
);
  import idm_pkg::*;

  logic              is_signed;
  logic              is_rem;
  logic              a_neg;
  logic              b_neg;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;
  stage_t            prep;

  always_comb begin
    case (opcode)
      OP_UDIV: begin
        is_signed = 1'b0;
        is_rem    = 1'b0;
      end
      OP_UREM: begin
        is_signed = 1'b0;
        is_rem    = 1'b1;
      end
      OP_SDIV: begin
        is_signed = 1'b1;
        is_rem    = 1'b0;
      end
      OP_SREM: begin
        is_signed = 1'b1;
        is_rem    = 1'b1;
      end
      default: begin
        is_signed = 1'b0;
        is_rem    = 1'b0;
      end
    endcase

    // the most negative word maps onto its own bit pattern, read unsigned
    a_neg = is_signed & dividend[DATA_W-1];
    b_neg = is_signed & divisor[DATA_W-1];
    a_mag = a_neg ? (~dividend + 1'b1) : dividend;
    b_mag = b_neg ? (~divisor + 1'b1) : divisor;

    prep.ctrl.sel_rem  = is_rem;
    prep.ctrl.negate   = is_rem ? a_neg : (a_neg ^ b_neg);
    prep.ctrl.zero_div = (divisor == '0);
    prep.rem           = '0;
    prep.nq            = a_mag;
    prep.den           = b_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= prep;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/idm_cell.sv -----
`default_nettype none

module idm_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            vin,
  input  wire idm_pkg::stage_t din,
  output logic                 vout,
  output idm_pkg::stage_t      dout
);
  import idm_pkg::*;

  logic              carry;
  logic [DATA_W-1:0] r_sh;
  logic [DATA_W:0]   diff;
  logic              take;
  stage_t            step;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    carry = din.rem[DATA_W-1];
    r_sh  = {din.rem[DATA_W-2:0], din.nq[DATA_W-1]};
    diff  = {carry, r_sh} - {1'b0, din.den};
    take  = ~diff[DATA_W];

    step.ctrl = din.ctrl;
    step.rem  = take ? diff[DATA_W-1:0] : r_sh;
    step.nq   = {din.nq[DATA_W-2:0], take};
    step.den  = din.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= step;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/integer_divide_modulo_32.sv -----
`default_nettype none

// Pipelined 32-bit integer divide / remainder unit.
//
// Input channel (s_axis): tuser carries the opcode (unsigned quotient,
// unsigned remainder, signed quotient, signed remainder), tdata carries
// the dividend in the low word and the divisor in the high word.
// Output channel (m_axis): tdata carries the 32-bit result. A zero divisor
// yields 0; signed quotients truncate toward zero and the signed remainder
// takes the dividend's sign. The most negative word over -1 wraps to itself.
//
// Throughput: one transfer per cycle while the skid entry is empty. Stages from
// input transfer to output valid: one operand conditioning stage, a row of 32
// restoring cells (one quotient bit each), and the output register.
// The whole row advances together; an output register plus a one-entry skid
// register absorb a stall, so s_axis_tready comes from a register and drops only
// after the skid entry fills while the receiver holds tready low. Nothing in
// flight is lost or repeated across a stall.
// Reset clears all valid bits; no item survives reset. No clearing pass.

module integer_divide_modulo_32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] dividend, [63:32] divisor
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [31:0] result
);
  import idm_pkg::*;

  logic              en;
  logic              vld [0:DATA_W];
  stage_t            stg [0:DATA_W];
  logic [DATA_W-1:0] sel_word;
  logic [DATA_W-1:0] res_word;
  logic              skid_full;
  logic [DATA_W-1:0] skid_data;

  // advance the row whenever the skid entry is free
  assign en            = ~skid_full;
  assign s_axis_tready = en;

  idm_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (s_axis_tvalid),
    .opcode   (s_axis_tuser),
    .dividend (s_axis_tdata[DATA_W-1:0]),
    .divisor  (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .vout     (vld[0]),
    .dout     (stg[0])
  );

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < DATA_W; i++) begin : g_cell
    idm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (vld[i]),
      .din  (stg[i]),
      .vout (vld[i+1]),
      .dout (stg[i+1])
    );
  end

  // pick quotient or remainder, fix the sign, force zero on a zero divisor
  always_comb begin
    sel_word = stg[DATA_W].ctrl.sel_rem ? stg[DATA_W].rem : stg[DATA_W].nq;
    if (stg[DATA_W].ctrl.zero_div) begin
      res_word = '0;
    end else if (stg[DATA_W].ctrl.negate) begin
      res_word = ~sel_word + 1'b1;
    end else begin
      res_word = sel_word;
    end
  end

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_full     <= 1'b0;
    end else if (skid_full) begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b1;
        skid_full     <= 1'b0;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= vld[DATA_W];
    end else if (vld[DATA_W]) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_data;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= res_word;
    end else begin
      skid_data <= res_word;
    end
  end

endmodule

`default_nettype wire
